// ----- src/cvg_pkg.sv -----
// shared types and constants of the circle vertex generator
// cordic arctangent table, gain, pipeline tag and register codes; no dependencies
package cvg_pkg;

  localparam int PhaseW = 32;
  localparam int XyW    = 34;
  localparam int ZW     = 33;
  localparam int TrigW  = 32;
  localparam int CoordW = 32;
  localparam int RadW   = 31;
  localparam int SideW  = 10;
  localparam int IdxW   = 11;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;
  localparam int AtanLen = 24;

  localparam logic [XyW-1:0] CordicGain = XyW'(652032874);

  localparam logic [CfgIdxW-1:0] RegCenterX   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRadius    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSideCount = 2'd3;

  localparam logic [31:0] AtanTurns [AtanLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic valid;
    logic err;
    logic center;
    logic flip;
  } cvg_tag_t;

endpackage

// ----- src/circle_vertex_generator_core.sv -----
// top level of the circle vertex generator: config registers, divider chain,
// cordic chain, scaling and saturation; depends on cvg_pkg, cvg_div_cell, cvg_cordic_cell
//
// usage:
//   a request is taken at a clock edge where start is high and busy is low;
//   vertex_index_i 0 gives the center, 1..sides+1 a rim point, larger sets
//   index_error_o with zero coordinates
//   every result shows on pos_x_o, pos_y_o, index_error_o for one cycle with
//   result_strobe_o high; the receiver cannot stall, results are never held
//   pipeline: one input stage, 32 divider cells, one cordic cell per rotation,
//   then sign fix, multiply, rounding and output stages
//   throughput: one request per cycle while busy is low, every stage is a register of the chain
//   reset: busy is high during reset and the cycle after, registers return to
//   center 0, radius 1.0, 360 sides; no request is then in flight
//   config writes are taken at any edge with cfg_we_i high and must only be
//   made while no request is in flight
module circle_vertex_generator_core #(
  parameter int MAX_SIDES     = 1023,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cvg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [cvg_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [cvg_pkg::IdxW-1:0]         vertex_index_i,
  output logic                             result_strobe_o,
  output logic signed [cvg_pkg::CoordW-1:0] pos_x_o,
  output logic signed [cvg_pkg::CoordW-1:0] pos_y_o,
  output logic                             index_error_o
);
  import cvg_pkg::*;

  localparam int SW   = $clog2(MAX_SIDES + 1);
  localparam int CmpW = ((SW > IdxW) ? SW : IdxW) + 2;
  localparam int NS   = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;
  localparam int NDIV = PhaseW;
  localparam int LAT  = NS + 37;

  // config registers
  logic [CoordW-1:0] center_x_q, center_y_q;
  logic [RadW-1:0]   radius_q;
  logic [SideW-1:0]  side_count_q;
  logic              ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      radius_q     <= RadW'(65536);
      side_count_q <= SideW'(360);
      ready_q      <= 1'b0;
    end else begin
      ready_q <= 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegCenterX:   center_x_q   <= cfg_wdata_i;
          RegCenterY:   center_y_q   <= cfg_wdata_i;
          RegRadius:    radius_q     <= cfg_wdata_i[RadW-1:0];
          RegSideCount: side_count_q <= cfg_wdata_i[SideW-1:0];
          default:      ;
        endcase
      end
    end
  end

  assign busy = !ready_q;

  logic accept;
  assign accept = start && !busy;

  // side count clamp and index checks
  logic [CmpW-1:0] side_ext, sides_cl, idx_ext, m_ext;
  logic [SW-1:0]   sides;
  logic [31:0]     half_ext;
  cvg_tag_t        in_tag;

  always_comb begin
    side_ext = CmpW'(side_count_q);
    if (side_ext < CmpW'(3)) begin
      sides_cl = CmpW'(3);
    end else if (side_ext > CmpW'(MAX_SIDES)) begin
      sides_cl = CmpW'(MAX_SIDES);
    end else begin
      sides_cl = side_ext;
    end
    sides    = sides_cl[SW-1:0];
    half_ext = 32'(sides) >> 1;
    idx_ext  = CmpW'(vertex_index_i);
    m_ext    = (idx_ext >= sides_cl) ? idx_ext - sides_cl : idx_ext;
    in_tag.valid  = accept;
    in_tag.err    = idx_ext > sides_cl + CmpW'(1);
    in_tag.center = idx_ext == '0;
    in_tag.flip   = 1'b0;
  end

  cvg_tag_t      s0_tag_q;
  logic [SW-1:0] s0_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_tag_q <= '0;
    end else begin
      s0_tag_q <= in_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_m_q <= m_ext[SW-1:0];
  end

  // phase = round(m * 2^32 / sides), one quotient bit per cell
  cvg_tag_t      div_tag [NDIV+1];
  logic [SW-1:0] div_rem [NDIV+1];
  logic [31:0]   div_quo [NDIV+1];

  assign div_tag[0] = s0_tag_q;
  assign div_rem[0] = s0_m_q;
  assign div_quo[0] = '0;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    cvg_div_cell #(.SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .sides_i (sides),
      .bit_i   (half_ext[NDIV-1-k]),
      .tag_i   (div_tag[k]),
      .rem_i   (div_rem[k]),
      .quo_i   (div_quo[k]),
      .tag_o   (div_tag[k+1]),
      .rem_o   (div_rem[k+1]),
      .quo_o   (div_quo[k+1])
    );
  end

  // half plane reduction into the cordic chain
  logic [31:0]    phase;
  logic           flip;
  cvg_tag_t       cor_tag [NS+1];
  logic signed [XyW-1:0] cor_x [NS+1];
  logic signed [XyW-1:0] cor_y [NS+1];
  logic signed [ZW-1:0]  cor_z [NS+1];

  assign phase      = div_quo[NDIV];
  assign flip       = phase[31] ^ phase[30];
  assign cor_tag[0] = '{valid:  div_tag[NDIV].valid,
                        err:    div_tag[NDIV].err,
                        center: div_tag[NDIV].center,
                        flip:   flip};
  assign cor_x[0]   = CordicGain;
  assign cor_y[0]   = '0;
  assign cor_z[0]   = ZW'($signed({phase[31] ^ flip, phase[30:0]}));

  for (genvar k = 0; k < NS; k++) begin : g_cordic
    cvg_cordic_cell #(.K(k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tag_i  (cor_tag[k]),
      .x_i    (cor_x[k]),
      .y_i    (cor_y[k]),
      .z_i    (cor_z[k]),
      .tag_o  (cor_tag[k+1]),
      .x_o    (cor_x[k+1]),
      .y_o    (cor_y[k+1]),
      .z_o    (cor_z[k+1])
    );
  end

  // sign fix, multiply, round, center add with saturation, error and center select
  cvg_tag_t             trig_tag_q, prod_tag_q, rnd_tag_q;
  logic signed [XyW-1:0] cos_n, sin_n;
  logic signed [TrigW-1:0] cos_q, sin_q;
  logic signed [63:0]   prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [63:0]   rnd_x, rnd_y;
  logic signed [XyW-1:0] off_x_q, off_y_q;
  logic signed [XyW:0]  sum_x, sum_y;
  logic signed [CoordW-1:0] out_x_d, out_y_d, pos_x_q, pos_y_q;
  logic                 strobe_q, err_q;

  localparam logic signed [XyW:0] SatHi = (XyW+1)'(64'sd2147483647);
  localparam logic signed [XyW:0] SatLo = -(XyW+1)'(64'sd2147483648);

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [XyW:0] v);
    logic signed [CoordW-1:0] r;
    if (v > SatHi) begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v < SatLo) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    cos_n    = cor_tag[NS].flip ? -cor_x[NS] : cor_x[NS];
    sin_n    = cor_tag[NS].flip ? -cor_y[NS] : cor_y[NS];
    prod_x_d = 64'($signed({1'b0, radius_q})) * 64'(cos_q);
    prod_y_d = 64'($signed({1'b0, radius_q})) * 64'(sin_q);
    rnd_x    = (prod_x_q + 64'sd536870912) >>> 30;
    rnd_y    = (prod_y_q + 64'sd536870912) >>> 30;
    sum_x    = (XyW+1)'($signed(center_x_q)) + (XyW+1)'(off_x_q);
    sum_y    = (XyW+1)'($signed(center_y_q)) + (XyW+1)'(off_y_q);
    if (rnd_tag_q.err) begin
      out_x_d = '0;
      out_y_d = '0;
    end else if (rnd_tag_q.center) begin
      out_x_d = center_x_q;
      out_y_d = center_y_q;
    end else begin
      out_x_d = sat_coord(sum_x);
      out_y_d = sat_coord(sum_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_tag_q <= '0;
      prod_tag_q <= '0;
      rnd_tag_q  <= '0;
      strobe_q   <= 1'b0;
    end else begin
      trig_tag_q <= cor_tag[NS];
      prod_tag_q <= trig_tag_q;
      rnd_tag_q  <= prod_tag_q;
      strobe_q   <= rnd_tag_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q    <= cos_n[TrigW-1:0];
    sin_q    <= sin_n[TrigW-1:0];
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    off_x_q  <= rnd_x[XyW-1:0];
    off_y_q  <= rnd_y[XyW-1:0];
    pos_x_q  <= out_x_d;
    pos_y_q  <= out_y_d;
    err_q    <= rnd_tag_q.err;
  end

  assign result_strobe_o = strobe_q;
  assign pos_x_o         = pos_x_q;
  assign pos_y_o         = pos_y_q;
  assign index_error_o   = err_q;

  // every request comes out exactly once after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT result_strobe_o)
    else $error("request lost in pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(accept, LAT))
    else $error("result without request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && index_error_o |-> pos_x_o == '0 && pos_y_o == '0)
    else $error("error result with nonzero coordinates");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_tag_q.valid |-> !(s0_tag_q.err && s0_tag_q.center))
    else $error("center index flagged as error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_tag[NDIV].valid && !div_tag[NDIV].err |-> div_rem[NDIV] < sides)
    else $error("divider remainder out of range");

endmodule

// ----- src/cvg_div_cell.sv -----
// one cell of the pipelined phase divider: one quotient bit per cell
// depends on cvg_pkg
module cvg_div_cell #(
  parameter int SW = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [SW-1:0]         sides_i,
  input  logic                  bit_i,
  input  cvg_pkg::cvg_tag_t     tag_i,
  input  logic [SW-1:0]         rem_i,
  input  logic [31:0]           quo_i,
  output cvg_pkg::cvg_tag_t     tag_o,
  output logic [SW-1:0]         rem_o,
  output logic [31:0]           quo_o
);
  import cvg_pkg::*;

  logic [SW:0]   trial;
  logic          ge;
  logic [SW:0]   diff;
  cvg_tag_t      tag_q;
  logic [SW-1:0] rem_q, rem_d;
  logic [31:0]   quo_q, quo_d;

  always_comb begin
    trial = {rem_i, bit_i};
    ge    = trial >= {1'b0, sides_i};
    diff  = trial - {1'b0, sides_i};
    rem_d = ge ? diff[SW-1:0] : trial[SW-1:0];
    quo_d = {quo_i[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign tag_o = tag_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// ----- src/cvg_cordic_cell.sv -----
// one rotation cell of the pipelined cordic, fixed shift per cell
// depends on cvg_pkg
module cvg_cordic_cell #(
  parameter int K = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cvg_pkg::cvg_tag_t             tag_i,
  input  logic signed [cvg_pkg::XyW-1:0] x_i,
  input  logic signed [cvg_pkg::XyW-1:0] y_i,
  input  logic signed [cvg_pkg::ZW-1:0]  z_i,
  output cvg_pkg::cvg_tag_t             tag_o,
  output logic signed [cvg_pkg::XyW-1:0] x_o,
  output logic signed [cvg_pkg::XyW-1:0] y_o,
  output logic signed [cvg_pkg::ZW-1:0]  z_o
);
  import cvg_pkg::*;

  localparam logic signed [ZW-1:0] Atan = ZW'(AtanTurns[K]);

  logic signed [XyW-1:0] dx, dy;
  logic signed [XyW-1:0] x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0]  z_d, z_q;
  cvg_tag_t              tag_q;

  always_comb begin
    dx = y_i >>> K;
    dy = x_i >>> K;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign tag_o = tag_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for circle_vertex_generator_core: random and edge-case vertex requests
// under several circle settings, checked against a cordic predictor in this file; needs cvg_pkg
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cvg_pkg::*;

  localparam int MaxSides      = 1023;
  localparam int CordicStages  = 16;
  localparam int Latency       = ((CordicStages > 24) ? 24 : CordicStages) + 37;
  localparam int RotLen        = 24;
  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 75;
  localparam int WatchdogLimit = 2000;
  localparam int MaxReports    = 10;

  localparam longint RotGainQ30 = 64'sd652032874;
  localparam logic [31:0] ArcTurns [RotLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [IdxW-1:0]   idx;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              err;
  } vertex_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = RegCenterX;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                start = 1'b0;
  logic                busy;
  logic [IdxW-1:0]     vertex_index_i = '0;
  logic                result_strobe_o;
  logic signed [CoordW-1:0] pos_x_o;
  logic signed [CoordW-1:0] pos_y_o;
  logic                index_error_o;

  logic [CoordW-1:0] circle_cx;
  logic [CoordW-1:0] circle_cy;
  logic [RadW-1:0]   circle_radius;
  logic [SideW-1:0]  circle_sides;

  logic [IdxW-1:0] pending_indexes [$];
  vertex_t         expected_vertices [$];
  int              gap_left;
  int              vertex_errors;
  int              idle_cycles;
  bit              no_idle;

  circle_vertex_generator_core #(
    .MAX_SIDES    (MaxSides),
    .CORDIC_STAGES(CordicStages)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .vertex_index_i (vertex_index_i),
    .result_strobe_o(result_strobe_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .index_error_o  (index_error_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned effective_sides();
    int unsigned s;
    s = circle_sides;
    if (s < 3) s = 3;
    if (s > MaxSides) s = MaxSides;
    return s;
  endfunction

  function automatic logic [CoordW-1:0] clamp_coord(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // cos and sin of a turn fraction, both Q2.30
  function automatic void rotate_unit(input logic [31:0] phase, output longint cs,
                                      output longint sn);
    logic   flip;
    longint x, y, z, dx, dy;
    int     n;
    flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    if (flip) phase = phase + 32'h8000_0000;
    x = RotGainQ30;
    y = 0;
    z = longint'(signed'(phase));
    n = (CordicStages > RotLen) ? RotLen : CordicStages;
    for (int k = 0; k < n; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ArcTurns[k]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ArcTurns[k]);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic vertex_t compute_vertex(logic [IdxW-1:0] idx);
    vertex_t           v;
    int unsigned       sides;
    longint unsigned   m, ph;
    longint            cs, sn, ox, oy;
    v = '0;
    v.idx = idx;
    sides = effective_sides();
    if (idx > sides + 1) begin
      v.err = 1'b1;
    end else if (idx == 0) begin
      v.x = circle_cx;
      v.y = circle_cy;
    end else begin
      m  = idx % sides;
      ph = ((m << 32) + (sides / 2)) / sides;
      rotate_unit(ph[31:0], cs, sn);
      ox = (longint'(circle_radius) * cs + 64'sd536870912) >>> 30;
      oy = (longint'(circle_radius) * sn + 64'sd536870912) >>> 30;
      v.x = clamp_coord(longint'(signed'(circle_cx)) + ox);
      v.y = clamp_coord(longint'(signed'(circle_cy)) + oy);
    end
    return v;
  endfunction

  function automatic logic [IdxW-1:0] pick_vertex_index();
    int unsigned s, r;
    s = effective_sides();
    r = $urandom_range(99, 0);
    if (r < 6) return '0;
    if (r < 12) return IdxW'(s + 1);
    if (r < 16) return IdxW'(s);
    if (r < 26) return IdxW'($urandom_range(2047, s + 2));
    return IdxW'($urandom_range(s + 1, 1));
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      RegCenterX:   circle_cx = data;
      RegCenterY:   circle_cy = data;
      RegRadius:    circle_radius = data[RadW-1:0];
      RegSideCount: circle_sides = data[SideW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_indexes.size() != 0 || start || expected_vertices.size() != 0)
      @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  task automatic apply_setting(int p);
    logic [CfgDataW-1:0] cx, cy, rad, sides;
    cx    = $urandom;
    cy    = $urandom;
    rad   = ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(32'h00FF_FFFF, 0);
    sides = {22'($urandom), 10'($urandom_range(1023, 0))};
    if ($urandom_range(1, 0) == 1) sides[SideW-1:0] = 10'($urandom_range(40, 3));
    case (p)
      1: begin
        cx = 32'h7FFF_FFFF; cy = 32'h8000_0000; rad = 32'h7FFF_FFFF; sides = 32'd3;
      end
      2: begin
        cx = 32'h8000_0000; cy = 32'h7FFF_FFFF; rad = 32'hFFFF_FFFF; sides = 32'hFFFF_FFFF;
      end
      3: begin
        cx = '0; cy = '0; rad = '0; sides = 32'd0;
      end
      4: sides[SideW-1:0] = 10'd1;
      5: sides[SideW-1:0] = 10'd2;
      6: sides[SideW-1:0] = 10'd1023;
      default: ;
    endcase
    write_reg(RegCenterX, cx);
    write_reg(RegCenterY, cy);
    write_reg(RegRadius, rad);
    write_reg(RegSideCount, sides);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // driver: one request in flight on the port, held while busy
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) expected_vertices.push_back(compute_vertex(vertex_index_i));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
          vertex_index_i <= IdxW'($urandom);
        end else if (pending_indexes.size() != 0) begin
          start <= 1'b1;
          vertex_index_i <= pending_indexes.pop_front();
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && result_strobe_o) begin
      if (expected_vertices.size() == 0) begin
        vertex_errors++;
        if (vertex_errors <= MaxReports)
          $display("unexpected result x=%h y=%h err=%b", pos_x_o, pos_y_o, index_error_o);
      end else begin
        want = expected_vertices.pop_front();
        if (pos_x_o !== want.x || pos_y_o !== want.y || index_error_o !== want.err) begin
          vertex_errors++;
          if (vertex_errors <= MaxReports)
            $display("mismatch index %0d: expected x=%h y=%h err=%b, got x=%h y=%h err=%b",
                     want.idx, want.x, want.y, want.err, pos_x_o, pos_y_o, index_error_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
  end

  initial begin
    circle_cx     = '0;
    circle_cy     = '0;
    circle_radius = RadW'(65536);
    circle_sides  = SideW'(360);
    gap_left      = 0;
    vertex_errors = 0;
    idle_cycles   = 0;
    no_idle       = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        wait_idle();
        apply_setting(p);
      end
      no_idle = (p % 3 == 2);
      if (p == 0) begin
        // quadrant points, wrap-around repeat, first out-of-range index and top codes
        pending_indexes = '{11'd0, 11'd1, 11'd45, 11'd90, 11'd135, 11'd180, 11'd225,
                            11'd270, 11'd315, 11'd359, 11'd360, 11'd361, 11'd362,
                            11'd1024, 11'd2047};
      end else if (p == 1) begin
        pending_indexes = '{11'd1, 11'd2, 11'd3, 11'd4, 11'd5};
      end
      repeat (ItemsPerPhase) pending_indexes.push_back(pick_vertex_index());
    end
    wait_idle();
    if (vertex_errors == 0 && expected_vertices.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
